// File: hw/rtl/lif_pkg.sv
`default_nettype none

package lif_pkg;

  // Fixed-point format of voltages, gains and currents (signed Q8.24)
  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 24;
  localparam int PROD_W    = 2 * VALUE_W;

  // Field widths
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 48;

  // Bank size and one state word (counter over voltage)
  localparam int NUM_NEURONS_DEF = 256;
  localparam int STATE_W         = COUNT_W + VALUE_W;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_RESET_V    = 3'd1,
    REG_DECAY      = 3'd2,
    REG_INPUT_GAIN = 3'd3,
    REG_BIAS       = 3'd4,
    REG_NOISE_GAIN = 3'd5,
    REG_REFR_STEPS = 3'd6
  } lif_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CURRENT,
    ST_LEAK,
    ST_SUM,
    ST_DONE
  } lif_state_t;

  // Saturating signed add
  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

  // Floor a full product to Q8.24 and saturate
  function automatic logic signed [VALUE_W-1:0] sat_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-FRAC_BITS-1:0] q;
    logic [PROD_W-FRAC_BITS-VALUE_W:0] hi;
    q  = p[PROD_W-1:FRAC_BITS];
    hi = q[PROD_W-FRAC_BITS-1:VALUE_W-1];
    if (!((&hi) || !(|hi))) begin
      return q[PROD_W-FRAC_BITS-1] ? VALUE_MIN : VALUE_MAX;
    end
    return q[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lif_ram.sv
`default_nettype none

module lif_ram #(
  parameter int WIDTH  = lif_pkg::STATE_W,
  parameter int DEPTH  = lif_pkg::NUM_NEURONS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lif_neuron_step.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    neuron_index, synaptic_input, noise_sample
// out_     master     out_tvalid/out_tready  result_index, spiked, membrane_voltage,
//                                            in_refractory
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A leaky update runs one state lookup, then three products through the single shared
// 32x32 multiplier, one per cycle, then the writeback. Refractory, firing and
// out-of-range requests skip the products and go from the lookup to the writeback.
// After reset every neuron reads as voltage 0 and counter 0 through per-entry valid
// bits; there is no clearing pass. cfg_ready is always high.
// A new request is taken while a result still waits; writeback stalls while the output
// register is full.

module lif_neuron_step #(
  parameter int NUM_NEURONS = lif_pkg::NUM_NEURONS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // [7:0] neuron_index, [39:8] synaptic_input, [71:40] noise_sample
  input  wire logic [lif_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] result_index, [8] spiked, [40:9] membrane_voltage, [41] in_refractory,
  // [47:42] zero
  output logic [lif_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lif_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [lif_pkg::VALUE_W-1:0]         cfg_data
);

  localparam int DEPTH  = (NUM_NEURONS < (1 << lif_pkg::INDEX_W)) ?
                          NUM_NEURONS : (1 << lif_pkg::INDEX_W);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW     = lif_pkg::VALUE_W;
  localparam int CW     = lif_pkg::COUNT_W;
  localparam int IW     = lif_pkg::INDEX_W;

  // Configuration registers
  logic signed [VW-1:0] thr_r, rst_v_r, decay_r, gain_r, bias_r, ngain_r;
  logic [CW-1:0]        refr_steps_r;

  // Sequencer and working registers
  lif_pkg::lif_state_t  state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic signed [VW-1:0] syn_r, syn_nxt, noise_r, noise_nxt;
  logic signed [VW-1:0] v_r, v_nxt, cur_r, cur_nxt, acc_r, acc_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 spk_r, spk_nxt, refr_r, refr_nxt, inrange_r, inrange_nxt;
  logic signed [lif_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [VW-1:0] mul_a, mul_b;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [IW-1:0]        out_idx_r, out_idx_nxt;
  logic                 out_spk_r, out_spk_nxt, out_refr_r, out_refr_nxt;
  logic signed [VW-1:0] out_v_r, out_v_nxt;
  logic                 out_free;

  // State store
  logic [DEPTH-1:0]             valid_r, valid_nxt;
  logic                         ram_we, ram_re;
  logic [ADDR_W-1:0]            ram_raddr, addr_r;
  logic [lif_pkg::STATE_W-1:0]  ram_rdata, ram_wdata;
  logic signed [VW-1:0]         rd_v;
  logic [CW-1:0]                rd_cnt;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign ram_raddr = in_tdata[ADDR_W-1:0];
  assign addr_r    = idx_r[ADDR_W-1:0];
  assign ram_wdata = {cnt_r, v_r};
  assign out_free  = !out_valid_r || out_tready;

  // Entries never written read as zero
  assign rd_v   = valid_r[addr_r] ? ram_rdata[VW-1:0] : '0;
  assign rd_cnt = valid_r[addr_r] ? ram_rdata[lif_pkg::STATE_W-1:VW] : '0;

  // Shared multiplier, registered every cycle
  assign prod_nxt = lif_pkg::PROD_W'(mul_a) * lif_pkg::PROD_W'(mul_b);

  lif_ram #(
    .WIDTH  (lif_pkg::STATE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Write configuration registers; unused indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= '0;
      rst_v_r      <= '0;
      decay_r      <= '0;
      gain_r       <= '0;
      bias_r       <= '0;
      ngain_r      <= '0;
      refr_steps_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lif_pkg::REG_THRESHOLD:  thr_r        <= cfg_data;
        lif_pkg::REG_RESET_V:    rst_v_r      <= cfg_data;
        lif_pkg::REG_DECAY:      decay_r      <= cfg_data;
        lif_pkg::REG_INPUT_GAIN: gain_r       <= cfg_data;
        lif_pkg::REG_BIAS:       bias_r       <= cfg_data;
        lif_pkg::REG_NOISE_GAIN: ngain_r      <= cfg_data;
        lif_pkg::REG_REFR_STEPS: refr_steps_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lif_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    syn_r      <= syn_nxt;
    noise_r    <= noise_nxt;
    v_r        <= v_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    spk_r      <= spk_nxt;
    refr_r     <= refr_nxt;
    inrange_r  <= inrange_nxt;
    prod_r     <= prod_nxt;
    out_idx_r  <= out_idx_nxt;
    out_spk_r  <= out_spk_nxt;
    out_refr_r <= out_refr_nxt;
    out_v_r    <= out_v_nxt;
  end

  // Sequencer: next state, datapath and outputs
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    syn_nxt       = syn_r;
    noise_nxt     = noise_r;
    v_nxt         = v_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    spk_nxt       = spk_r;
    refr_nxt      = refr_r;
    inrange_nxt   = inrange_r;
    mul_a         = noise_r;
    mul_b         = ngain_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_spk_nxt   = out_spk_r;
    out_refr_nxt  = out_refr_r;
    out_v_nxt     = out_v_r;
    valid_nxt     = valid_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    in_tready     = 1'b0;

    unique case (state_r)
      lif_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ram_re      = 1'b1;
          idx_nxt     = in_tdata[IW-1:0];
          syn_nxt     = in_tdata[IW+VW-1:IW];
          noise_nxt   = in_tdata[IW+2*VW-1:IW+VW];
          inrange_nxt = 32'(in_tdata[IW-1:0]) < 32'(NUM_NEURONS);
          state_nxt   = lif_pkg::ST_LOOKUP;
        end
      end

      // Pick the branch; start the noise product
      lif_pkg::ST_LOOKUP: begin
        spk_nxt  = 1'b0;
        refr_nxt = 1'b0;
        cnt_nxt  = '0;
        if (!inrange_r) begin
          v_nxt     = '0;
          state_nxt = lif_pkg::ST_DONE;
        end else if (rd_cnt != '0) begin
          refr_nxt  = 1'b1;
          cnt_nxt   = rd_cnt - CW'(1);
          v_nxt     = rd_v;
          state_nxt = lif_pkg::ST_DONE;
        end else if (rd_v >= thr_r) begin
          spk_nxt   = 1'b1;
          cnt_nxt   = refr_steps_r;
          v_nxt     = rst_v_r;
          state_nxt = lif_pkg::ST_DONE;
        end else begin
          v_nxt     = rd_v;
          cur_nxt   = lif_pkg::sat_add(syn_r, bias_r);
          state_nxt = lif_pkg::ST_CURRENT;
        end
      end

      // Add scaled noise; multiply decay by voltage
      lif_pkg::ST_CURRENT: begin
        cur_nxt   = lif_pkg::sat_add(cur_r, lif_pkg::sat_prod(prod_r));
        mul_a     = decay_r;
        mul_b     = v_r;
        state_nxt = lif_pkg::ST_LEAK;
      end

      // Hold leak term; multiply gain by current
      lif_pkg::ST_LEAK: begin
        acc_nxt   = lif_pkg::sat_prod(prod_r);
        mul_a     = gain_r;
        mul_b     = cur_r;
        state_nxt = lif_pkg::ST_SUM;
      end

      lif_pkg::ST_SUM: begin
        v_nxt     = lif_pkg::sat_add(acc_r, lif_pkg::sat_prod(prod_r));
        state_nxt = lif_pkg::ST_DONE;
      end

      // Write back and present the result once the output register is free
      lif_pkg::ST_DONE: begin
        if (out_free) begin
          ram_we        = inrange_r;
          if (inrange_r) begin
            valid_nxt[addr_r] = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_spk_nxt   = spk_r;
          out_refr_nxt  = refr_r;
          out_v_nxt     = v_r;
          state_nxt     = lif_pkg::ST_IDLE;
        end
      end

      default: state_nxt = lif_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_refr_r, out_v_r, out_spk_r, out_idx_r};

  // One request at a time: a taken request closes the input
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request accepted while another is in flight");

  // A step never both fires and counts down
  a_spike_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[41]))
    else $error("spiked and in_refractory both set");

  // Writeback and result load happen together
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_tvalid && (out_tdata[IW-1:0] == $past(idx_r)))
    else $error("state writeback without matching result");

  // Out-of-range results carry zero fields
  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !(32'(out_tdata[IW-1:0]) < 32'(NUM_NEURONS)) |->
      out_tdata[41:8] == '0)
    else $error("out-of-range result with nonzero fields");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lif_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 20;
  localparam int QUIET_LIMIT  = 2000;  // outlasts the longest hold-off, HOLD_CYCLES
  localparam int HOLD_CYCLES  = 200;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               spiked;
    logic [VALUE_W-1:0] volt;
    logic               refr;
  } step_result_t;

  typedef struct packed {
    logic         pinned;
    step_result_t res;
  } pin_entry_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_STEP, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] addr;
    logic [VALUE_W-1:0]     data;
    logic [INDEX_W-1:0]     idx;
    logic [VALUE_W-1:0]     syn;
    logic [VALUE_W-1:0]     noise;
    step_result_t           want;
  } plan_row_t;

  typedef enum logic [1:0] {SET_MILD, SET_WIDE, SET_LOW, SET_HIGH} setting_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_DATA_W-1:0]   in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [VALUE_W-1:0]     cfg_data   = '0;

  // Neuron bank and register copy used for prediction
  logic signed [VALUE_W-1:0] volt_mem  [NUM_NEURONS_DEF];
  logic [COUNT_W-1:0]        count_mem [NUM_NEURONS_DEF];
  logic signed [VALUE_W-1:0] thr_reg, reset_reg, decay_reg, gain_reg, bias_reg;
  logic signed [VALUE_W-1:0] noise_gain_reg;
  logic [COUNT_W-1:0]        refr_steps_reg;

  step_result_t expected_steps [$];
  pin_entry_t   pinned_results [$];
  int           issued    = 0;
  int           retired   = 0;
  int           failures  = 0;
  int           send_idle = 0;
  int           stall_pct = 0;
  int           hold_left = 0;

  lif_neuron_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Q8.24 product, floored toward minus infinity, then saturated
  function automatic logic signed [VALUE_W-1:0] fx_mul(input logic signed [VALUE_W-1:0] a,
                                                       input logic signed [VALUE_W-1:0] b);
    logic signed [PROD_W-1:0] wide;
    wide = PROD_W'(a) * PROD_W'(b);
    wide = wide >>> FRAC_BITS;
    if (wide > VALUE_MAX) return VALUE_MAX;
    if (wide < VALUE_MIN) return VALUE_MIN;
    return wide[VALUE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] fx_add(input logic signed [VALUE_W-1:0] a,
                                                       input logic signed [VALUE_W-1:0] b);
    logic signed [VALUE_W:0] s;
    s = (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
    if (s > VALUE_MAX) return VALUE_MAX;
    if (s < VALUE_MIN) return VALUE_MIN;
    return s[VALUE_W-1:0];
  endfunction

  // Advance one neuron of the bank and return what the block should report
  function automatic step_result_t advance_neuron(input logic [INDEX_W-1:0] idx,
                                                  input logic signed [VALUE_W-1:0] syn,
                                                  input logic signed [VALUE_W-1:0] noise);
    step_result_t              r;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] cur;
    r     = '0;
    r.idx = idx;
    v     = volt_mem[idx];
    if (count_mem[idx] != '0) begin
      r.refr = 1'b1;
      count_mem[idx] = count_mem[idx] - COUNT_W'(1);
    end else if (v >= thr_reg) begin
      r.spiked = 1'b1;
      v = reset_reg;
      count_mem[idx] = refr_steps_reg;
    end else begin
      cur = fx_add(syn, bias_reg);
      cur = fx_add(cur, fx_mul(noise, noise_gain_reg));
      v   = fx_add(fx_mul(decay_reg, v), fx_mul(gain_reg, cur));
    end
    volt_mem[idx] = v;
    r.volt = v;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [INDEX_W-1:0] idx,
                                      input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: neuron %0d %s mismatch, expected %h, actual %h",
               $time, idx, label, want, got);
    end
  endfunction

  // Track register writes, predict accepted requests, check results in order
  always @(posedge clk) begin : track_steps
    step_result_t want;
    step_result_t got;
    pin_entry_t   pin;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:  thr_reg        = cfg_data;
          REG_RESET_V:    reset_reg      = cfg_data;
          REG_DECAY:      decay_reg      = cfg_data;
          REG_INPUT_GAIN: gain_reg       = cfg_data;
          REG_BIAS:       bias_reg       = cfg_data;
          REG_NOISE_GAIN: noise_gain_reg = cfg_data;
          REG_REFR_STEPS: refr_steps_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = advance_neuron(in_tdata[7:0], in_tdata[39:8], in_tdata[71:40]);
        if (pinned_results.size() != 0) begin
          pin = pinned_results.pop_front();
          if (pin.pinned) want = pin.res;
        end
        expected_steps.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.idx    = out_tdata[7:0];
        got.spiked = out_tdata[8];
        got.volt   = out_tdata[40:9];
        got.refr   = out_tdata[41];
        retired++;
        if (expected_steps.size() == 0) begin
          failures++;
          $display("%0t: result for neuron %0d arrived with nothing expected, actual %h",
                   $time, got.idx, got);
        end else begin
          want = expected_steps.pop_front();
          check_field("result_index", want.idx, VALUE_W'(want.idx), VALUE_W'(got.idx));
          check_field("spiked", want.idx, VALUE_W'(want.spiked), VALUE_W'(got.spiked));
          check_field("membrane_voltage", want.idx, want.volt, got.volt);
          check_field("in_refractory", want.idx, VALUE_W'(want.refr), VALUE_W'(got.refr));
        end
      end
    end
  end

  // Result side: random stalls, plus a counted hold-off when one is requested
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run when nothing is accepted for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] addr,
                                        input logic [VALUE_W-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t step_row(input logic [INDEX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] syn,
                                         input logic [VALUE_W-1:0] noise);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_STEP;
    r.idx   = idx;
    r.syn   = syn;
    r.noise = noise;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [INDEX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] syn,
                                          input logic [VALUE_W-1:0] noise,
                                          input logic spiked, input logic [VALUE_W-1:0] volt,
                                          input logic refr);
    plan_row_t r;
    r             = step_row(idx, syn, noise);
    r.kind        = ROW_KNOWN;
    r.want.idx    = idx;
    r.want.spiked = spiked;
    r.want.volt   = volt;
    r.want.refr   = refr;
    return r;
  endfunction

  // Offer one request; valid stays high on return so back-to-back requests never drop it
  task automatic push_request(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] syn,
                              input logic [VALUE_W-1:0] noise, input logic pinned,
                              input step_result_t res);
    pin_entry_t e;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    e.pinned = pinned;
    e.res    = res;
    pinned_results.push_back(e);
    in_tdata  <= {noise, syn, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    issued++;
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a batch
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] addr, input logic [VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drop the request, let every result come back, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (retired != issued) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 20) return $urandom;
    return $urandom_range(32'h0400_0000) - 32'h0100_0000;
  endfunction

  task automatic program_regs(input setting_t kind);
    logic [VALUE_W-1:0] thr, rst_v, decay, gain, bias, ngain, steps;
    case (kind)
      SET_HIGH: begin
        thr = VALUE_MAX; rst_v = VALUE_MAX; decay = VALUE_MAX;
        gain = VALUE_MAX; bias = VALUE_MAX; ngain = VALUE_MAX;
        steps = 32'h0000_FFFF;
      end
      SET_LOW: begin
        thr = VALUE_MIN; rst_v = VALUE_MIN; decay = VALUE_MIN;
        gain = VALUE_MIN; bias = VALUE_MIN; ngain = VALUE_MIN;
        steps = 32'hFFFF_0000;
      end
      SET_WIDE: begin
        thr = $urandom; rst_v = $urandom; decay = $urandom;
        gain = $urandom; bias = $urandom; ngain = $urandom;
        steps = {16'($urandom), 16'($urandom_range(6))};
      end
      default: begin
        // Gains near one and a low threshold so neurons charge, fire and recover
        thr   = $urandom_range(32'h0400_0000, 32'h0100_0000);
        rst_v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
        decay = $urandom_range(32'h0100_0000, 32'h0080_0000);
        gain  = $urandom_range(32'h0100_0000, 32'h0040_0000);
        bias  = $urandom_range(32'h0080_0000) - 32'h0040_0000;
        ngain = $urandom_range(32'h0100_0000) - 32'h0080_0000;
        steps = {16'($urandom), 16'($urandom_range(4))};
      end
    endcase
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RESET_V, rst_v);
    write_reg(REG_DECAY, decay);
    write_reg(REG_INPUT_GAIN, gain);
    write_reg(REG_BIAS, bias);
    write_reg(REG_NOISE_GAIN, ngain);
    write_reg(REG_REFR_STEPS, steps);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: drain, new settings, new idling and stalling, then a run of random requests
  task automatic run_phase(input setting_t kind, input int idle_pct, input int stall_in,
                           input int count, input int hold);
    logic [INDEX_W-1:0] idx;
    wait_idle();
    program_regs(kind);
    @(negedge clk);
    stall_pct = stall_in;
    hold_left = hold;
    send_idle = idle_pct;
    @(posedge clk);
    repeat (count) begin
      // mostly a small group of neurons so their voltages evolve over many steps
      idx = ($urandom_range(99) < 75) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      push_request(idx, pick_value(), pick_value(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    plan_row_t plan [$];
    for (int n = 0; n < NUM_NEURONS_DEF; n++) begin
      volt_mem[n]  = '0;
      count_mem[n] = '0;
    end
    thr_reg = '0; reset_reg = '0; decay_reg = '0; gain_reg = '0;
    bias_reg = '0; noise_gain_reg = '0; refr_steps_reg = '0;

    // Registers at reset: threshold 0, so a fresh neuron fires at once
    plan.push_back(known_row(8'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0));
    plan.push_back(known_row(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0));
    // Unit gains, top threshold, counter field with junk in the upper bits
    plan.push_back(reg_row(REG_THRESHOLD, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_RESET_V, 32'h8000_0000));
    plan.push_back(reg_row(REG_DECAY, 32'h0100_0000));
    plan.push_back(reg_row(REG_INPUT_GAIN, 32'h0100_0000));
    plan.push_back(reg_row(REG_BIAS, 32'h0000_0000));
    plan.push_back(reg_row(REG_NOISE_GAIN, 32'h0000_0000));
    plan.push_back(reg_row(REG_REFR_STEPS, 32'hFFFF_0003));
    plan.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(known_row(8'd1, 32'h0100_0000, 32'h7FFF_FFFF, 1'b0, 32'h0100_0000, 1'b0));
    // Sum saturates high, then fires at the top threshold
    plan.push_back(known_row(8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(known_row(8'd1, 32'h0, 32'h0, 1'b1, 32'h8000_0000, 1'b0));
    // Three refractory steps hold the reset level
    plan.push_back(known_row(8'd1, 32'h0, 32'h0, 1'b0, 32'h8000_0000, 1'b1));
    plan.push_back(known_row(8'd1, 32'h0, 32'h0, 1'b0, 32'h8000_0000, 1'b1));
    plan.push_back(known_row(8'd1, 32'h0, 32'h0, 1'b0, 32'h8000_0000, 1'b1));
    // Sum saturates low
    plan.push_back(known_row(8'd1, 32'h8000_0000, 32'h0, 1'b0, 32'h8000_0000, 1'b0));
    // Negative gains: flooring of negative products and saturation
    plan.push_back(reg_row(REG_THRESHOLD, 32'h4000_0000));
    plan.push_back(reg_row(REG_RESET_V, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_DECAY, 32'hFF80_0000));
    plan.push_back(reg_row(REG_INPUT_GAIN, 32'h8000_0000));
    plan.push_back(reg_row(REG_BIAS, 32'h0000_0001));
    plan.push_back(reg_row(REG_NOISE_GAIN, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_REFR_STEPS, 32'h0000_FFFF));
    plan.push_back(step_row(8'd2, 32'h0000_0003, 32'hFFFF_FFFF));
    plan.push_back(step_row(8'd2, 32'h8000_0000, 32'h8000_0000));
    plan.push_back(step_row(8'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plan.push_back(step_row(8'd4, 32'hFFFF_FFFF, 32'h0000_0001));
    plan.push_back(step_row(8'd2, 32'h0000_0000, 32'h0000_0000));
    // Lowest threshold: fire and load the longest refractory count
    plan.push_back(reg_row(REG_THRESHOLD, 32'h8000_0000));
    plan.push_back(known_row(8'd200, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(known_row(8'd200, 32'h0, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(known_row(8'd128, 32'h1234_5678, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan; writes only go out once the block has drained
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) wait_idle();
        write_reg(plan[i].addr, plan[i].data);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_WRITE) cfg_valid <= 1'b0;
      end else begin
        push_request(plan[i].idx, plan[i].syn, plan[i].noise, plan[i].kind == ROW_KNOWN,
                     plan[i].want);
      end
    end

    run_phase(SET_MILD, 0, 0, 300, 0);
    run_phase(SET_MILD, 68, 0, 250, 0);
    run_phase(SET_WIDE, 0, 68, 250, 0);
    run_phase(SET_LOW, 31, 31, 100, 0);
    run_phase(SET_MILD, 31, 31, 300, 0);
    run_phase(SET_MILD, 0, 0, 200, HOLD_CYCLES);
    run_phase(SET_HIGH, 0, 0, 150, 0);

    in_tvalid <= 1'b0;
    while (retired != issued) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_steps.size() != 0) begin
      failures++;
      $display("%0t: %0d expected results never arrived", $time, expected_steps.size());
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
